// ===== hdl/sfpx_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpx_pkg
// Shared constants, register indexes, state encoding and the command/status
// structs that pass between the frame parser controller and its datapath.
// ----------------------------------------------------------------------------
package sfpx_pkg;

    localparam int FRAME_BUFFER_BYTES = 32;
    localparam int PAYLOAD_CAP        = FRAME_BUFFER_BYTES - 6;
    localparam int ADDR_W             = $clog2(PAYLOAD_CAP);
    localparam int BYTE_W             = 8;
    localparam int LEN_W              = 5;
    localparam int CFG_IDX_W          = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_FIRST    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SECOND   = 2'd3;

    // configuration reset values
    localparam logic [BYTE_W-1:0] RST_HEADER_FIRST  = 8'd170;
    localparam logic [BYTE_W-1:0] RST_HEADER_SECOND = 8'd85;
    localparam logic [BYTE_W-1:0] RST_TAIL_FIRST    = 8'd13;
    localparam logic [BYTE_W-1:0] RST_TAIL_SECOND   = 8'd10;

    typedef enum logic [8:0] {
        ST_HDR1  = 9'b000000001,
        ST_HDR2  = 9'b000000010,
        ST_CMD   = 9'b000000100,
        ST_LEN   = 9'b000001000,
        ST_DATA  = 9'b000010000,
        ST_CHK   = 9'b000100000,
        ST_TAIL1 = 9'b001000000,
        ST_TAIL2 = 9'b010000000,
        ST_EMIT  = 9'b100000000
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_cmd;    // capture command byte, seed checksum
        logic load_len;    // capture length, clear fill count
        logic store_byte;  // write payload byte, fold into checksum
        logic start_run;   // frame complete, point read at entry 0
        logic step_run;    // current result word taken
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hdr1_hit;
        logic hdr2_hit;
        logic len_ok;
        logic len_zero;
        logic fill_done;
        logic chk_hit;
        logic tail1_hit;
        logic tail2_hit;
        logic run_last;
    } sts_t;

endpackage

// ===== hdl/sfpx_ram.sv =====
// ----------------------------------------------------------------------------
// sfpx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfpx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 26
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/sfpx_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfpx_ctrl
// Frame parser state machine: walks the frame fields and sequences the
// result run.
// ----------------------------------------------------------------------------
module sfpx_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  sfpx_pkg::sts_t sts,
    output sfpx_pkg::cmd_t cmd
);
    import sfpx_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   in_acc;

    assign in_stall  = (state_reg == ST_EMIT);
    assign out_valid = (state_reg == ST_EMIT);
    assign in_acc    = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load_cmd   = 1'b0;
        cmd.load_len   = 1'b0;
        cmd.store_byte = 1'b0;
        cmd.start_run  = 1'b0;
        cmd.step_run   = 1'b0;
        case (state_reg)
            ST_HDR1:
            begin
                if (in_acc && sts.hdr1_hit)
                begin
                    state_next = ST_HDR2;
                end
            end
            ST_HDR2:
            begin
                if (in_acc)
                begin
                    state_next = sts.hdr2_hit ? ST_CMD : ST_HDR1;
                end
            end
            ST_CMD:
            begin
                if (in_acc)
                begin
                    cmd.load_cmd = 1'b1;
                    state_next   = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (in_acc)
                begin
                    if (!sts.len_ok)
                    begin
                        state_next = ST_HDR1;
                    end
                    else
                    begin
                        cmd.load_len = 1'b1;
                        state_next   = sts.len_zero ? ST_CHK : ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (in_acc)
                begin
                    cmd.store_byte = 1'b1;
                    if (sts.fill_done)
                    begin
                        state_next = ST_CHK;
                    end
                end
            end
            ST_CHK:
            begin
                if (in_acc)
                begin
                    state_next = sts.chk_hit ? ST_TAIL1 : ST_HDR1;
                end
            end
            ST_TAIL1:
            begin
                if (in_acc)
                begin
                    state_next = sts.tail1_hit ? ST_TAIL2 : ST_HDR1;
                end
            end
            ST_TAIL2:
            begin
                if (in_acc)
                begin
                    if (sts.tail2_hit)
                    begin
                        cmd.start_run = 1'b1;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_HDR1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    cmd.step_run = 1'b1;
                    if (sts.run_last)
                    begin
                        state_next = ST_HDR1;
                    end
                end
            end
            default:
            begin
                state_next = ST_HDR1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HDR1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/sfpx_dp.sv =====
// ----------------------------------------------------------------------------
// sfpx_dp
// Parser datapath: config registers, field compares, running XOR checksum,
// payload buffer and result field generation.
// ----------------------------------------------------------------------------
module sfpx_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sfpx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfpx_pkg::BYTE_W-1:0]       cfg_data,
    input  logic [sfpx_pkg::BYTE_W-1:0]       rx_byte,
    input  sfpx_pkg::cmd_t                    cmd,
    output sfpx_pkg::sts_t                    sts,
    output logic [sfpx_pkg::BYTE_W-1:0]       command,
    output logic [sfpx_pkg::LEN_W-1:0]        payload_length,
    output logic [sfpx_pkg::LEN_W-1:0]        byte_index,
    output logic [sfpx_pkg::BYTE_W-1:0]       payload_byte,
    output logic                              has_payload,
    output logic                              last
);
    import sfpx_pkg::*;

    logic [BYTE_W-1:0] header_first_reg;
    logic [BYTE_W-1:0] header_second_reg;
    logic [BYTE_W-1:0] tail_first_reg;
    logic [BYTE_W-1:0] tail_second_reg;
    logic [BYTE_W-1:0] command_reg;
    logic [LEN_W-1:0]  length_reg;
    logic [LEN_W-1:0]  fill_reg;
    logic [BYTE_W-1:0] chk_reg;
    logic [LEN_W-1:0]  idx_reg;

    logic [BYTE_W-1:0] chk_next;
    logic [LEN_W-1:0]  fill_next;
    logic [LEN_W-1:0]  idx_next;
    logic [LEN_W:0]    fill_inc;
    logic [LEN_W:0]    idx_inc;
    logic              run_empty;
    logic [BYTE_W-1:0] rdata;

    // status compares
    assign fill_inc = {1'b0, fill_reg} + 1'b1;
    assign idx_inc  = {1'b0, idx_reg} + 1'b1;
    assign run_empty = (length_reg == '0);

    assign sts.hdr1_hit  = (rx_byte == header_first_reg);
    assign sts.hdr2_hit  = (rx_byte == header_second_reg);
    assign sts.len_ok    = (rx_byte <= BYTE_W'(PAYLOAD_CAP));
    assign sts.len_zero  = (rx_byte == '0);
    assign sts.fill_done = (fill_inc >= {1'b0, length_reg});
    assign sts.chk_hit   = (rx_byte == chk_reg);
    assign sts.tail1_hit = (rx_byte == tail_first_reg);
    assign sts.tail2_hit = (rx_byte == tail_second_reg);
    assign sts.run_last  = run_empty || (idx_inc == {1'b0, length_reg});

    always_comb
    begin
        chk_next = chk_reg;
        if (cmd.load_cmd)
        begin
            chk_next = rx_byte;
        end
        else if (cmd.load_len || cmd.store_byte)
        begin
            chk_next = chk_reg ^ rx_byte;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.load_len)
        begin
            fill_next = '0;
        end
        else if (cmd.store_byte)
        begin
            fill_next = fill_inc[LEN_W-1:0];
        end
    end

    // read address runs one step ahead so the RAM output lines up with idx_reg
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.start_run)
        begin
            idx_next = '0;
        end
        else if (cmd.step_run && !sts.run_last)
        begin
            idx_next = idx_inc[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= RST_HEADER_FIRST;
            header_second_reg <= RST_HEADER_SECOND;
            tail_first_reg    <= RST_TAIL_FIRST;
            tail_second_reg   <= RST_TAIL_SECOND;
            command_reg       <= '0;
            length_reg        <= '0;
            fill_reg          <= '0;
            chk_reg           <= '0;
            idx_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                    CFG_HEADER_SECOND: header_second_reg <= cfg_data;
                    CFG_TAIL_FIRST:    tail_first_reg    <= cfg_data;
                    CFG_TAIL_SECOND:   tail_second_reg   <= cfg_data;
                    default:           tail_second_reg   <= tail_second_reg;
                endcase
            end
            if (cmd.load_cmd)
            begin
                command_reg <= rx_byte;
            end
            if (cmd.load_len)
            begin
                length_reg <= rx_byte[LEN_W-1:0];
            end
            fill_reg <= fill_next;
            chk_reg  <= chk_next;
            idx_reg  <= idx_next;
        end
    end

    sfpx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_CAP)
    ) u_store (
        .clk   (clk),
        .we    (cmd.store_byte),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (rx_byte),
        .raddr (idx_next[ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign command        = command_reg;
    assign payload_length = length_reg;
    assign byte_index     = idx_reg;
    assign payload_byte   = run_empty ? '0 : rdata;
    assign has_payload    = !run_empty;
    assign last           = sts.run_last;

endmodule

// ===== hdl/serial_frame_parser_xor.sv =====
// ----------------------------------------------------------------------------
// serial_frame_parser_xor
// Timing: the first result word is valid the cycle after the accepted second
//   tail byte.
// Throughput: one byte per cycle while parsing; a valid frame then emits one
//   result word per cycle whenever out_stall is low (length words, or one for
//   an empty payload) while the input is stalled, so a frame of L payload bytes
//   costs L+7 bytes plus max(L,1) result words.
// Reset (rst_n, async, active low): parser hunts for the first header, config
//   registers return to their defaults; the payload buffer is not cleared.
// ----------------------------------------------------------------------------
//
// Frame: hdr1, hdr2, command, length, payload[length], checksum, tail1, tail2.
// The checksum is the XOR of command, length and payload, accumulated as the
// bytes arrive, so the check byte is compared against a register directly.
// Any mismatch (second header, oversize length, checksum, either tail byte)
// consumes the byte and drops back to hunting for the first header.
//
// Payload bytes land in a small RAM with a registered read port. During the
// result run the read address is driven from the next index, so the RAM
// output always matches the word currently on the output; the run advances
// one entry per cycle whenever the downstream side does not stall.
//
// The controller (sfpx_ctrl) owns the frame state and the handshakes; the
// datapath (sfpx_dp) owns config, field compares, checksum, buffer and the
// result fields.
// ----------------------------------------------------------------------------
module serial_frame_parser_xor (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic [sfpx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfpx_pkg::BYTE_W-1:0]    cfg_data,
    // received byte channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [sfpx_pkg::BYTE_W-1:0]    rx_byte,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [sfpx_pkg::BYTE_W-1:0]    command,
    output logic [sfpx_pkg::LEN_W-1:0]     payload_length,
    output logic [sfpx_pkg::LEN_W-1:0]     byte_index,
    output logic [sfpx_pkg::BYTE_W-1:0]    payload_byte,
    output logic                           has_payload,
    output logic                           last
);
    import sfpx_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sfpx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    sfpx_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .sts            (sts),
        .command        (command),
        .payload_length (payload_length),
        .byte_index     (byte_index),
        .payload_byte   (payload_byte),
        .has_payload    (has_payload),
        .last           (last)
    );

endmodule

// ===== hdl/sfpx_chk.sv =====
// ----------------------------------------------------------------------------
// sfpx_chk
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module sfpx_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [sfpx_pkg::BYTE_W-1:0]    payload_byte,
    input logic [sfpx_pkg::LEN_W-1:0]     byte_index,
    input logic                           has_payload,
    input logic                           last
);
    import sfpx_pkg::*;

    // no byte is taken while a result run is on the output
    a_stall_during_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !out_valid)
        else $error("input accepted during result run");

    // a run does not break until its last word
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("result run ended early");

    // the run ends right after its last word is taken
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last) |=> !out_valid)
        else $error("extra word after last");

    // an empty frame gives one word with zero index and data
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_payload) |-> (last && byte_index == '0 && payload_byte == '0))
        else $error("malformed empty-payload word");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(payload_byte)
            && $stable(byte_index)))
        else $error("stalled result word changed");

endmodule

bind serial_frame_parser_xor sfpx_chk u_sfpx_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .has_payload  (has_payload),
    .last         (last)
);
